@@ sv/ftp_passive_reply_parser_macros.svh @@
// assertion macros shared by the passive reply parser modules
`ifndef FTP_PASSIVE_REPLY_PARSER_MACROS_SVH
`define FTP_PASSIVE_REPLY_PARSER_MACROS_SVH

// same-cycle implication, checked out of reset
`define FPR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define FPR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/fpr_pkg.sv @@
// types and constants of the passive reply parser
`default_nettype none
package fpr_pkg;

   localparam logic [7:0] CHR_NL     = 8'h0A;
   localparam logic [7:0] CHR_TWO    = 8'h32;
   localparam logic [7:0] CHR_SEVEN  = 8'h37;
   localparam logic [7:0] CHR_NINE   = 8'h39;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_OPEN   = 8'h28;
   localparam logic [7:0] CHR_CLOSE  = 8'h29;
   localparam logic [7:0] CHR_COMMA  = 8'h2C;

   localparam logic [1:0] CLASS_OTHER = 2'd0;

   localparam logic [2:0] LAST_OCTET_FIELD = 3'd3;
   localparam logic [2:0] HIGH_PORT_FIELD  = 3'd4;
   localparam logic [2:0] LOW_PORT_FIELD   = 3'd5;
   localparam logic [2:0] SKIP_LAST        = 3'd2;
   localparam logic [1:0] PREFIX_LEN       = 2'd3;

   typedef enum logic [2:0] {
      PH_SEEK    = 3'd0,
      PH_SKIP    = 3'd1,
      PH_DIGITS  = 3'd2,
      PH_STOPPED = 3'd3,
      PH_DONE    = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      PFX_NONE  = 2'd0,
      PFX_227   = 2'd1,
      PFX_229   = 2'd2,
      PFX_MATCH = 2'd3
   } prefix_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  line_class;
      logic [31:0] server_address;
      logic [15:0] server_port;
   } result_type;

   function automatic logic [31:0] put_octet(logic [31:0] held, logic [2:0] idx,
                                             logic [15:0] value);
      logic [31:0] res;
      res = held;
      unique case (idx)
         3'd0: res[31:24] = held[31:24] | value[7:0];
         3'd1: res[23:16] = held[23:16] | value[7:0];
         3'd2: res[15:8]  = held[15:8]  | value[7:0];
         3'd3: res[7:0]   = held[7:0]   | value[7:0];
         default: res = held;
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

@@ sv/fpr_line_parser.sv @@
// per-line parse state and reply decode of the passive reply parser
`default_nettype none
`include "ftp_passive_reply_parser_macros.svh"
module fpr_line_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step_en,
   input  wire logic [7:0]         data_byte,
   input  wire logic               end_of_payload,
   input  wire logic [31:0]        peer_address,
   output fpr_pkg::result_type     result
);
   import fpr_pkg::*;

   logic [1:0]  line_pos_ff, line_pos_in;
   prefix_type  prefix_ff, prefix_in;
   phase_type   phase_ff, phase_in;
   logic [2:0]  field_ff, field_in;
   logic [15:0] acc_ff, acc_in;
   logic [31:0] octet_ff, octet_in;
   logic [7:0]  high_ff, high_in;
   logic [31:0] saddr_ff, saddr_in;
   logic [15:0] sport_ff, sport_in;
   logic        nonempty_ff, nonempty_in;

   logic        is_nl;
   logic        is_digit;
   logic        closing;
   logic        emit;
   logic [1:0]  cls;
   logic [15:0] low;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pos_ff <= '0;
         prefix_ff   <= PFX_NONE;
         phase_ff    <= PH_SEEK;
         field_ff    <= '0;
         acc_ff      <= '0;
         octet_ff    <= '0;
         high_ff     <= '0;
         saddr_ff    <= '0;
         sport_ff    <= '0;
         nonempty_ff <= 1'b0;
      end else if (step_en) begin
         line_pos_ff <= line_pos_in;
         prefix_ff   <= prefix_in;
         phase_ff    <= phase_in;
         field_ff    <= field_in;
         acc_ff      <= acc_in;
         octet_ff    <= octet_in;
         high_ff     <= high_in;
         saddr_ff    <= saddr_in;
         sport_ff    <= sport_in;
         nonempty_ff <= nonempty_in;
      end
   end

   always_comb begin
      line_pos_in = line_pos_ff;
      prefix_in   = prefix_ff;
      phase_in    = phase_ff;
      field_in    = field_ff;
      acc_in      = acc_ff;
      octet_in    = octet_ff;
      high_in     = high_ff;
      saddr_in    = saddr_ff;
      sport_in    = sport_ff;
      nonempty_in = nonempty_ff;
      low         = '0;
      cls         = CLASS_OTHER;
      is_nl       = (data_byte == CHR_NL);
      is_digit    = (data_byte >= CHR_ZERO) && (data_byte <= CHR_NINE);

      // take one line byte
      if (!is_nl) begin
         nonempty_in = 1'b1;
         if (line_pos_ff != PREFIX_LEN) begin
            unique case (line_pos_ff)
               2'd0: prefix_in = (data_byte == CHR_TWO) ? PFX_MATCH : PFX_NONE;
               2'd1: prefix_in = (prefix_ff == PFX_MATCH && data_byte == CHR_TWO) ?
                                 PFX_MATCH : PFX_NONE;
               default: begin
                  if (prefix_ff == PFX_MATCH && data_byte == CHR_SEVEN) begin
                     prefix_in = PFX_227;
                  end else if (prefix_ff == PFX_MATCH && data_byte == CHR_NINE) begin
                     prefix_in = PFX_229;
                  end else begin
                     prefix_in = PFX_NONE;
                  end
               end
            endcase
            line_pos_in = line_pos_ff + 2'd1;
         end else if (prefix_ff == PFX_227 || prefix_ff == PFX_229) begin
            unique case (phase_ff)
               PH_SEEK: begin
                  if (data_byte == CHR_OPEN) begin
                     phase_in = (prefix_ff == PFX_229) ? PH_SKIP : PH_DIGITS;
                     field_in = '0;
                     acc_in   = '0;
                     octet_in = '0;
                     high_in  = '0;
                  end
               end
               PH_SKIP: begin
                  if (field_ff >= SKIP_LAST) begin
                     field_in = '0;
                     phase_in = PH_DIGITS;
                  end else begin
                     field_in = field_ff + 3'd1;
                  end
               end
               PH_DIGITS, PH_STOPPED: begin
                  if (prefix_ff == PFX_227 &&
                      ((field_ff < LOW_PORT_FIELD && data_byte == CHR_COMMA) ||
                       (field_ff >= LOW_PORT_FIELD && data_byte == CHR_CLOSE))) begin
                     // field separator
                     if (field_ff <= LAST_OCTET_FIELD) begin
                        octet_in = put_octet(octet_ff, field_ff, acc_ff);
                        field_in = field_ff + 3'd1;
                        acc_in   = '0;
                        phase_in = PH_DIGITS;
                     end else if (field_ff == HIGH_PORT_FIELD) begin
                        high_in  = acc_ff[7:0];
                        field_in = field_ff + 3'd1;
                        acc_in   = '0;
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end else if (phase_ff == PH_DIGITS && is_digit) begin
                     acc_in = {acc_ff[12:0], 3'b000} + {acc_ff[14:0], 1'b0}
                              + {12'd0, data_byte[3:0]};
                  end else begin
                     phase_in = PH_STOPPED;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      // close the line
      closing = is_nl || end_of_payload;
      emit    = closing && nonempty_in;
      if (emit) begin
         if (prefix_in == PFX_227 || prefix_in == PFX_229) begin
            cls = prefix_in;
         end
         if (prefix_in == PFX_227 && phase_in != PH_SEEK) begin
            if (phase_in == PH_DONE) begin
               low = acc_in;
            end else if (field_in <= LAST_OCTET_FIELD) begin
               octet_in = put_octet(octet_in, field_in, acc_in);
            end else if (field_in == HIGH_PORT_FIELD) begin
               high_in = acc_in[7:0];
            end else begin
               low = acc_in;
            end
            saddr_in = octet_in;
            sport_in = {high_in, 8'h00} + low;
         end else if (prefix_in == PFX_229 && phase_in != PH_SEEK) begin
            saddr_in = peer_address;
            sport_in = (phase_in == PH_SKIP) ? 16'd0 : acc_in;
         end
      end

      result.valid          = emit;
      result.line_class     = cls;
      result.server_address = saddr_in;
      result.server_port    = sport_in;

      if (closing) begin
         line_pos_in = '0;
         prefix_in   = PFX_NONE;
         phase_in    = PH_SEEK;
         field_in    = '0;
         acc_in      = '0;
         octet_in    = '0;
         high_in     = '0;
         nonempty_in = 1'b0;
      end
   end

   `FPR_ASSERT_IMP(a_phase_after_prefix, phase_ff != PH_SEEK,
      line_pos_ff == PREFIX_LEN && (prefix_ff == PFX_227 || prefix_ff == PFX_229),
      "parse phase left seek without a reply prefix")
   `FPR_ASSERT_IMP(a_field_range, 1'b1, field_ff <= LOW_PORT_FIELD,
      "field index past the port low byte")
   `FPR_ASSERT_IMP(a_skip_count, phase_ff == PH_SKIP, field_ff <= SKIP_LAST,
      "skip counter overran")

endmodule
`default_nettype wire

@@ sv/ftp_passive_reply_parser.sv @@
// path: a request is held in the input register, parsed from there, and its reply held in the result register
// throughput: one request per cycle while the result side is ready
// every byte passes a single parse step; a result register parts it from the reply side
// reset: synchronous, clears parse state, stored address, stored port and peer address
// the stored address and port read as zero until a passive reply is seen
`default_nettype none
`include "ftp_passive_reply_parser_macros.svh"
module ftp_passive_reply_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic        req_tlast,   // end_of_payload
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // server_address [31:0], server_port [47:32]
   output logic [1:0]       rsp_tuser,   // line_class
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata    // peer_address
);
   import fpr_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic [31:0] peer_ff;
   logic        rsp_valid_ff;
   logic [47:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;
   logic        out_free;
   logic        step_en;
   result_type  result;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         peer_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (out_free) begin
            rsp_valid_ff <= step_en && result.valid;
         end
         if (csr_we) begin
            peer_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step_en && result.valid) begin
         rsp_data_ff <= {result.server_port, result.server_address};
         rsp_user_ff <= result.line_class;
      end
   end

   fpr_line_parser u_line_parser (
      .clock          (clock),
      .reset          (reset),
      .step_en        (step_en),
      .data_byte      (in_byte_ff),
      .end_of_payload (in_last_ff),
      .peer_address   (peer_ff),
      .result         (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `FPR_ASSERT_IMP(a_step_only_when_free, step_en, !rsp_valid_ff || rsp_tready,
      "request stepped while a result was stalled")
   `FPR_ASSERT_IMP(a_result_from_step, $rose(rsp_valid_ff), $past(step_en),
      "result appeared without a request step")
   `FPR_ASSERT_NXT(a_ready_after_step, step_en && !(req_tvalid && req_tready), req_tready,
      "input stage still full after its request moved on")

endmodule
`default_nettype wire
